// File: rtl/apag_pkg.sv
// ----------------------------------------------------------------------------
// apag_pkg
// Shared widths, constants and register indexes for the peak, activity and
// gain block.
// ----------------------------------------------------------------------------
package apag_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 16;
  localparam int HOLD_W     = 10;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_UNITY  = GAIN_W'(1 << GAIN_FRAC);
  localparam logic [HOLD_W-1:0] HOLD_RESET  = HOLD_W'(10);
  localparam int                IN_DATA_W   = 16;
  localparam int                OUT_DATA_W  = 32;
  localparam int                OUT_USER_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_THRESHOLD = 2'd0,
    REG_HOLD_FRAMES    = 2'd1,
    REG_MUTE           = 2'd2,
    REG_GAIN           = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/audio_peak_activity_gain.sv
// ----------------------------------------------------------------------------
// audio_peak_activity_gain
// Frame peak detection with held activity flag and Q4.12 output gain.
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  sample, frame end, no-data
//   m_axis   out  m_axis_tvalid/m_axis_tready  sample, peak, valid, presence
//   cfg      in   cfg_we                       register index and data
//
// One request per cycle sustained while m_axis is ready; a request passes
// through the input register, then the result register, to result valid.
// Peak, silence counter and activity flag update as a request moves from
// the input register to the result register.
// Stalls on m_axis back up through both registers; rst clears all control
// state and restores register defaults.
// ----------------------------------------------------------------------------
module audio_peak_activity_gain (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] sample_in
  input  logic [apag_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // [0] no_data
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] sample_out, [31:16] frame_peak
  output logic [apag_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  // [0] sample_valid, [1] input_active
  output logic [apag_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  input  logic                                 cfg_we,
  input  logic [apag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apag_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import apag_pkg::*;

  logic [PEAK_W-1:0] peak_threshold;
  logic [HOLD_W-1:0] hold_frames;
  logic              mute;
  logic [GAIN_W-1:0] gain;

  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last;
  logic                       in_nodata;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_svalid;
  logic                       out_done;
  logic [PEAK_W-1:0]          out_peak;
  logic                       out_present;

  logic [PEAK_W-1:0] running_peak;
  logic [HOLD_W-1:0] silence_count;
  logic              activity_flag;

  logic [PEAK_W-1:0] running_peak_next;
  logic [HOLD_W-1:0] silence_count_next;
  logic              activity_flag_next;

  logic                       out_adv;
  logic                       in_adv;
  logic [PEAK_W-1:0]          abs_val;
  logic [PEAK_W-1:0]          peak_max;
  logic [PEAK_W-1:0]          close_peak;
  logic                       closing;
  logic signed [SAMPLE_W-1:0] scaled;

  assign out_adv       = !out_valid || m_axis_tready;
  assign in_adv        = in_valid && out_adv;
  assign s_axis_tready = !in_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= '0;
      hold_frames    <= HOLD_RESET;
      mute           <= 1'b0;
      gain           <= GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[PEAK_W-1:0];
        REG_HOLD_FRAMES:    hold_frames    <= cfg_data[HOLD_W-1:0];
        REG_MUTE:           mute           <= cfg_data[0];
        REG_GAIN:           gain           <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      in_last   <= s_axis_tlast;
      in_nodata <= s_axis_tuser;
    end
  end

  apag_scale u_scale (
    .sample (in_sample),
    .gain   (gain),
    .mute   (mute),
    .result (scaled)
  );

  assign abs_val    = in_sample[SAMPLE_W-1] ? PEAK_W'(-in_sample) : PEAK_W'(in_sample);
  assign peak_max   = (abs_val > running_peak) ? abs_val : running_peak;
  assign closing    = in_nodata || in_last;
  assign close_peak = in_nodata ? '0 : peak_max;

  always_comb begin
    running_peak_next  = closing ? '0 : peak_max;
    silence_count_next = silence_count;
    activity_flag_next = activity_flag;
    if (closing) begin
      if (close_peak >= peak_threshold) begin
        silence_count_next = '0;
        activity_flag_next = 1'b1;
      end else if (silence_count < hold_frames) begin
        silence_count_next = silence_count + HOLD_W'(1);
      end else begin
        activity_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak  <= '0;
      silence_count <= '0;
      activity_flag <= 1'b0;
    end else if (in_adv) begin
      running_peak  <= running_peak_next;
      silence_count <= silence_count_next;
      activity_flag <= activity_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_sample  <= in_nodata ? '0 : scaled;
      out_svalid  <= !in_nodata;
      out_done    <= closing;
      out_peak    <= (in_last && !in_nodata) ? peak_max : '0;
      out_present <= activity_flag_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_peak, out_sample};
  assign m_axis_tlast  = out_done;
  assign m_axis_tuser  = {out_present, out_svalid};

  a_nodata_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_svalid |-> out_done && out_sample == '0 && out_peak == '0)
    else $error("no-data result must close a silent frame");

  a_midframe_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_done |-> out_peak == '0)
    else $error("mid-frame result carries a peak");

  a_peak_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done && out_peak >= peak_threshold |-> out_present)
    else $error("frame above threshold did not set presence");

  a_mute_zero: assert property (@(posedge clk) disable iff (rst)
    in_adv && mute |=> out_sample == '0)
    else $error("muted request produced a nonzero sample");

endmodule

// File: rtl/apag_scale.sv
// ----------------------------------------------------------------------------
// apag_scale
// Mute, unity bypass and Q4.12 gain with round-half-away and int16 clamp.
// ----------------------------------------------------------------------------
module apag_scale (
  input  logic signed [apag_pkg::SAMPLE_W-1:0] sample,
  input  logic        [apag_pkg::GAIN_W-1:0]   gain,
  input  logic                                 mute,
  output logic signed [apag_pkg::SAMPLE_W-1:0] result
);
  import apag_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam logic [PROD_W-1:0] HALF      = PROD_W'(1 << (GAIN_FRAC - 1));
  localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(1 << (SAMPLE_W - 1));
  localparam logic [SAMPLE_W-1:0] S_MAX   = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [SAMPLE_W-1:0] S_MIN   = SAMPLE_W'(1 << (SAMPLE_W - 1));

  logic signed [PROD_W-1:0] prod;
  logic        [PROD_W-1:0] mag;
  logic        [PROD_W-1:0] rnd;
  logic        [SAMPLE_W-1:0] scaled;
  logic                       neg;

  assign prod = PROD_W'(sample) * $signed({1'b0, gain});
  assign neg  = prod[PROD_W-1];
  assign mag  = neg ? PROD_W'(-prod) : PROD_W'(prod);
  assign rnd  = (mag + HALF) >> GAIN_FRAC;

  always_comb begin
    if (neg) begin
      if (rnd > NEG_LIMIT) begin
        scaled = S_MIN;
      end else begin
        scaled = SAMPLE_W'(-rnd[SAMPLE_W-1:0]);
      end
    end else begin
      if (rnd > POS_LIMIT) begin
        scaled = S_MAX;
      end else begin
        scaled = rnd[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (mute) begin
      result = '0;
    end else if (gain == GAIN_UNITY) begin
      result = sample;
    end else begin
      result = $signed(scaled);
    end
  end

endmodule
